@@ hdl/priority_depth_draw_sorter_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the draw-order sorter
// Shared property wrappers; every check is clocked on clk.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_DEPTH_DRAW_SORTER_DEFINES_SVH
`define PRIORITY_DEPTH_DRAW_SORTER_DEFINES_SVH

// Check that is switched off while reset is asserted.
`define PDDS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pdds check failed");

// Check that also holds while reset is asserted.
`define PDDS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("pdds check failed");

`endif

@@ hdl/pdds_pkg.sv @@
// ----------------------------------------------------------------------------
// pdds_pkg
// Widths, register indexes and controller commands of the draw-order sorter.
// ----------------------------------------------------------------------------
package pdds_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int IDX_W   = 16;
    localparam int PRI_W   = 16;
    localparam int POS_W   = 32;
    localparam int DIR_W   = 16;
    localparam int DIFF_W  = POS_W + 1;
    localparam int PROD_W  = DIFF_W + DIR_W;
    localparam int DEPTH_W = 50;
    localparam int WORD_W  = IDX_W + PRI_W + DEPTH_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CAM_POS_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_POS_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_POS_Z     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_DIR_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_DIR_Y     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CAM_DIR_Z     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK_TO_FRONT = 3'd6;

    localparam logic [DIR_W-1:0] CAM_DIR_Z_RESET = 16'h8000;

    typedef struct packed {
        logic load;       // capture position differences of an accepted item
        logic mul;        // register the three products
        logic wr;         // write the depth sum and item fields to the store
        logic scan_rd;    // scan read issued this cycle
        logic take_best;  // winner data is on the read port
        logic set_done;   // last result of the set delivered
    } cmd_t;

endpackage

@@ hdl/pdds_ram.sv @@
// ----------------------------------------------------------------------------
// pdds_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module pdds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/pdds_datapath.sv @@
// ----------------------------------------------------------------------------
// pdds_datapath
// Camera registers, depth pipeline, item store and the running minimum search.
// ----------------------------------------------------------------------------
module pdds_datapath #(
    parameter int CAPACITY = pdds_pkg::CAPACITY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pdds_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pdds_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [pdds_pkg::IDX_W-1:0]          item_index,
    input  logic signed [pdds_pkg::PRI_W-1:0]   item_priority,
    input  logic signed [pdds_pkg::POS_W-1:0]   pos_x,
    input  logic signed [pdds_pkg::POS_W-1:0]   pos_y,
    input  logic signed [pdds_pkg::POS_W-1:0]   pos_z,
    input  pdds_pkg::cmd_t                      cmd,
    input  logic [$clog2(CAPACITY)-1:0]         wr_addr,
    input  logic [$clog2(CAPACITY)-1:0]         rd_addr,
    output logic [$clog2(CAPACITY)-1:0]         best_addr,
    output logic [pdds_pkg::IDX_W-1:0]          out_index,
    output logic signed [pdds_pkg::DEPTH_W-1:0] out_depth
);
    import pdds_pkg::*;

    localparam int AW    = $clog2(CAPACITY);
    localparam int KEY_W = PRI_W + DEPTH_W + AW;

    logic signed [POS_W-1:0] cam_pos_x_reg, cam_pos_y_reg, cam_pos_z_reg;
    logic signed [DIR_W-1:0] cam_dir_x_reg, cam_dir_y_reg, cam_dir_z_reg;
    logic                    back_to_front_reg;

    logic signed [DIFF_W-1:0]  dx_reg, dy_reg, dz_reg;
    logic signed [PROD_W-1:0]  px_reg, py_reg, pz_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic [PRI_W-1:0]          pri_reg;
    logic signed [DEPTH_W-1:0] depth_sum;
    logic [WORD_W-1:0]         wdata, rdata;

    logic              cmp_en_reg;
    logic [AW-1:0]     cmp_addr_reg;
    logic [KEY_W-1:0]  best_key_reg, prev_key_reg, cand_key;
    logic              best_valid_reg, has_prev_reg;
    logic [DEPTH_W-1:0] cand_depth;
    logic              cand_wins;
    logic [IDX_W-1:0]  out_index_reg;
    logic signed [DEPTH_W-1:0] out_depth_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_pos_x_reg     <= '0;
            cam_pos_y_reg     <= '0;
            cam_pos_z_reg     <= '0;
            cam_dir_x_reg     <= '0;
            cam_dir_y_reg     <= '0;
            cam_dir_z_reg     <= CAM_DIR_Z_RESET;
            back_to_front_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CAM_POS_X:     cam_pos_x_reg     <= cfg_data;
                CFG_CAM_POS_Y:     cam_pos_y_reg     <= cfg_data;
                CFG_CAM_POS_Z:     cam_pos_z_reg     <= cfg_data;
                CFG_CAM_DIR_X:     cam_dir_x_reg     <= cfg_data[DIR_W-1:0];
                CFG_CAM_DIR_Y:     cam_dir_y_reg     <= cfg_data[DIR_W-1:0];
                CFG_CAM_DIR_Z:     cam_dir_z_reg     <= cfg_data[DIR_W-1:0];
                CFG_BACK_TO_FRONT: back_to_front_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Depth pipeline: differences, then products, then the sum at the write.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dx_reg  <= {cam_pos_x_reg[POS_W-1], cam_pos_x_reg} - {pos_x[POS_W-1], pos_x};
            dy_reg  <= {cam_pos_y_reg[POS_W-1], cam_pos_y_reg} - {pos_y[POS_W-1], pos_y};
            dz_reg  <= {cam_pos_z_reg[POS_W-1], cam_pos_z_reg} - {pos_z[POS_W-1], pos_z};
            idx_reg <= item_index;
            pri_reg <= item_priority;
        end
        if (cmd.mul)
        begin
            px_reg <= dx_reg * cam_dir_x_reg;
            py_reg <= dy_reg * cam_dir_y_reg;
            pz_reg <= dz_reg * cam_dir_z_reg;
        end
    end

    assign depth_sum = DEPTH_W'(px_reg) + DEPTH_W'(py_reg) + DEPTH_W'(pz_reg);
    assign wdata     = {idx_reg, pri_reg, depth_sum};

    pdds_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (cmd.wr),
        .waddr (wr_addr),
        .wdata (wdata),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    // The sort key is unique: priority, depth (inverted for back to front), then
    // arrival slot. Each result is the smallest key above the one emitted before.
    assign cand_depth = back_to_front_reg ? ~rdata[DEPTH_W-1:0] : rdata[DEPTH_W-1:0];
    assign cand_key   = {rdata[DEPTH_W+PRI_W-1] ^ 1'b1, rdata[DEPTH_W+PRI_W-2:DEPTH_W],
                         cand_depth[DEPTH_W-1] ^ 1'b1, cand_depth[DEPTH_W-2:0],
                         cmp_addr_reg};
    assign cand_wins  = cmp_en_reg && (!has_prev_reg || cand_key > prev_key_reg)
                        && (!best_valid_reg || cand_key < best_key_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_en_reg     <= 1'b0;
            best_valid_reg <= 1'b0;
            has_prev_reg   <= 1'b0;
        end
        else
        begin
            cmp_en_reg <= cmd.scan_rd;
            if (cand_wins)
            begin
                best_valid_reg <= 1'b1;
            end
            if (cmd.take_best)
            begin
                best_valid_reg <= 1'b0;
                has_prev_reg   <= 1'b1;
            end
            if (cmd.set_done)
            begin
                has_prev_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_addr_reg <= rd_addr;
        if (cand_wins)
        begin
            best_key_reg <= cand_key;
        end
        if (cmd.take_best)
        begin
            prev_key_reg  <= best_key_reg;
            out_index_reg <= rdata[WORD_W-1:PRI_W+DEPTH_W];
            out_depth_reg <= rdata[DEPTH_W-1:0];
        end
    end

    assign best_addr = best_key_reg[AW-1:0];
    assign out_index = out_index_reg;
    assign out_depth = out_depth_reg;

endmodule

@@ hdl/pdds_ctrl.sv @@
// ----------------------------------------------------------------------------
// pdds_ctrl
// Sequencer for loading items, scanning the store and handing out results.
// ----------------------------------------------------------------------------
`include "priority_depth_draw_sorter_defines.svh"

module pdds_ctrl #(
    parameter int CAPACITY = pdds_pkg::CAPACITY_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        last_item,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        overflowed,
    output logic                        last_out,
    output pdds_pkg::cmd_t              cmd,
    output logic [$clog2(CAPACITY)-1:0] wr_addr,
    output logic [$clog2(CAPACITY)-1:0] rd_addr,
    input  logic [$clog2(CAPACITY)-1:0] best_addr
);
    import pdds_pkg::*;

    localparam int AW    = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DIFF, S_MUL, S_WR, S_SCAN, S_DRAIN, S_FETCH, S_LOADOUT, S_OUT
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] count_reg;
    logic             ovf_reg, last_reg;
    logic [AW-1:0]    scan_reg, pos_reg;
    logic             out_valid_reg, out_last_reg, out_ovf_reg;
    logic             accept, full;
    logic [CNT_W-1:0] count_m1;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign count_m1 = count_reg - CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            last_reg      <= 1'b0;
            scan_reg      <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        last_reg <= last_item;
                        scan_reg <= '0;
                        pos_reg  <= '0;
                        if (full)
                        begin
                            ovf_reg   <= 1'b1;
                            state_reg <= last_item ? S_SCAN : S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_DIFF;
                        end
                    end
                end
                S_DIFF:  state_reg <= S_MUL;
                S_MUL:   state_reg <= S_WR;
                S_WR:
                begin
                    count_reg <= count_reg + CNT_W'(1);
                    state_reg <= last_reg ? S_SCAN : S_IDLE;
                end
                S_SCAN:
                begin
                    if (CNT_W'(scan_reg) == count_m1)
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + AW'(1);
                    end
                end
                S_DRAIN: state_reg <= S_FETCH;
                S_FETCH: state_reg <= S_LOADOUT;
                S_LOADOUT:
                begin
                    out_valid_reg <= 1'b1;
                    out_last_reg  <= (CNT_W'(pos_reg) == count_m1);
                    out_ovf_reg   <= ovf_reg;
                    state_reg     <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        scan_reg      <= '0;
                        if (out_last_reg)
                        begin
                            count_reg <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            pos_reg   <= pos_reg + AW'(1);
                            state_reg <= S_SCAN;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb
    begin
        cmd           = '0;
        cmd.load      = accept;
        cmd.mul       = (state_reg == S_MUL);
        cmd.wr        = (state_reg == S_WR);
        cmd.scan_rd   = (state_reg == S_SCAN);
        cmd.take_best = (state_reg == S_LOADOUT);
        cmd.set_done  = (state_reg == S_OUT) && !out_stall && out_last_reg;
    end

    assign wr_addr    = count_reg[AW-1:0];
    assign rd_addr    = (state_reg == S_FETCH) ? best_addr : scan_reg;
    assign in_stall   = (state_reg != S_IDLE);
    assign out_valid  = out_valid_reg;
    assign last_out   = out_last_reg;
    assign overflowed = out_ovf_reg;

    `PDDS_ASSERT(a_count_bound, count_reg <= CNT_W'(CAPACITY))
    `PDDS_ASSERT(a_out_holds, (state_reg == S_OUT && out_stall) |=> state_reg == S_OUT)
    `PDDS_ASSERT(a_set_clears,
        (state_reg == S_OUT && !out_stall && out_last_reg) |=> (count_reg == '0 && !ovf_reg))
    `PDDS_ASSERT(a_valid_in_out, out_valid_reg |-> state_reg == S_OUT)
    `PDDS_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !out_valid_reg)

endmodule

@@ hdl/priority_depth_draw_sorter.sv @@
// ----------------------------------------------------------------------------
// priority_depth_draw_sorter
// Collects draw items with a view-depth key and returns them sorted by
// priority, then depth, then arrival.
//
//   channel  | direction | handshake              | beat carries
//   ---------+-----------+------------------------+------------------------------
//   input    | in        | in_valid / in_stall    | item_index .. last_item
//   output   | out       | out_valid / out_stall  | out_index, out_depth, flags
//   config   | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Loading an item runs through differences, products, then sum and store write.
// Each sorted result comes from a scan of the set in the item store over its
// single read port, and a stalled output holds it back.
// Reset clears the item count and the overflow flag; the store needs no clearing.
// Input is stalled while an item loads and while a set is being returned.
// ----------------------------------------------------------------------------
module priority_depth_draw_sorter #(
    parameter int CAPACITY = pdds_pkg::CAPACITY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [pdds_pkg::IDX_W-1:0]          item_index,
    input  logic signed [pdds_pkg::PRI_W-1:0]   item_priority,
    input  logic signed [pdds_pkg::POS_W-1:0]   pos_x,
    input  logic signed [pdds_pkg::POS_W-1:0]   pos_y,
    input  logic signed [pdds_pkg::POS_W-1:0]   pos_z,
    input  logic                                last_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [pdds_pkg::IDX_W-1:0]          out_index,
    output logic signed [pdds_pkg::DEPTH_W-1:0] out_depth,
    output logic                                overflowed,
    output logic                                last_out,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pdds_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pdds_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import pdds_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    cmd_t          cmd;
    logic [AW-1:0] wr_addr, rd_addr, best_addr;

    // Writes are for the user to make only while idle; not enforced, the port is open.
    assign cfg_ready = 1'b1;

    pdds_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .last_item  (last_item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .overflowed (overflowed),
        .last_out   (last_out),
        .cmd        (cmd),
        .wr_addr    (wr_addr),
        .rd_addr    (rd_addr),
        .best_addr  (best_addr)
    );

    pdds_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item_index    (item_index),
        .item_priority (item_priority),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .pos_z         (pos_z),
        .cmd           (cmd),
        .wr_addr       (wr_addr),
        .rd_addr       (rd_addr),
        .best_addr     (best_addr),
        .out_index     (out_index),
        .out_depth     (out_depth)
    );

endmodule

@@ sim/tb_priority_depth_draw_sorter.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the draw-order sorter
// Sends sets of draw items through the input channel, predicts the sorted
// beats with its own depth and ordering logic, and checks each output beat
// in order. Camera registers and the sort direction change between sets.
// ----------------------------------------------------------------------------
module tb_priority_depth_draw_sorter;
    import pdds_pkg::*;

    localparam int CAP = CAPACITY_DEF;
    localparam int WATCH_LIMIT = 200000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct {
        logic [IDX_W-1:0]          idx;
        logic signed [DEPTH_W-1:0] depth;
        logic                      ovf;
        logic                      last;
    } sorted_beat_t;

    class draw_order_scoreboard;
        logic signed [POS_W-1:0] cpx, cpy, cpz;
        logic signed [DIR_W-1:0] cdx, cdy, cdz;
        logic                    desc;
        logic [IDX_W-1:0]          st_idx[CAP];
        logic signed [PRI_W-1:0]   st_pri[CAP];
        logic signed [DEPTH_W-1:0] st_dep[CAP];
        int                        count;
        logic                      ovf;
        sorted_beat_t              pending[$];
        int                        errors;

        function void reset_state();
            cpx = 0; cpy = 0; cpz = 0;
            cdx = 0; cdy = 0; cdz = CAM_DIR_Z_RESET;
            desc = 0; count = 0; ovf = 0; errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] ri, logic [CFG_DATA_W-1:0] d);
            case (ri)
                CFG_CAM_POS_X:     cpx = d;
                CFG_CAM_POS_Y:     cpy = d;
                CFG_CAM_POS_Z:     cpz = d;
                CFG_CAM_DIR_X:     cdx = d[DIR_W-1:0];
                CFG_CAM_DIR_Y:     cdy = d[DIR_W-1:0];
                CFG_CAM_DIR_Z:     cdz = d[DIR_W-1:0];
                CFG_BACK_TO_FRONT: desc = d[0];
                default: ;
            endcase
        endfunction

        function bit ahead(int a, int b);
            if (st_pri[a] != st_pri[b]) return st_pri[a] < st_pri[b];
            if (desc) return st_dep[a] > st_dep[b];
            return st_dep[a] < st_dep[b];
        endfunction

        function void note_item(logic [IDX_W-1:0] idx, logic signed [PRI_W-1:0] pri,
                                logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py,
                                logic signed [POS_W-1:0] pz, logic lst);
            longint dx, dy, dz;
            int order[CAP];
            int j;
            sorted_beat_t b;
            if (count < CAP) begin
                dx = longint'(cpx) - longint'(px);
                dy = longint'(cpy) - longint'(py);
                dz = longint'(cpz) - longint'(pz);
                st_idx[count] = idx;
                st_pri[count] = pri;
                st_dep[count] = DEPTH_W'(dx * longint'(cdx) + dy * longint'(cdy)
                                         + dz * longint'(cdz));
                count++;
            end else begin
                ovf = 1;
            end
            if (!lst) return;
            // Insertion sort keeps equal keys in arrival order.
            for (int i = 0; i < count; i++) begin
                j = i;
                while (j > 0 && ahead(i, order[j-1])) begin
                    order[j] = order[j-1];
                    j--;
                end
                order[j] = i;
            end
            for (int i = 0; i < count; i++) begin
                b.idx = st_idx[order[i]];
                b.depth = st_dep[order[i]];
                b.ovf = ovf;
                b.last = (i == count - 1);
                pending.push_back(b);
            end
            count = 0;
            ovf = 0;
        endfunction

        task check_beat(logic [IDX_W-1:0] idx, logic signed [DEPTH_W-1:0] dep,
                        logic o, logic l);
            sorted_beat_t e;
            if (pending.size() == 0) begin
                report_mismatch($sformatf("unexpected beat index %0d", idx));
                return;
            end
            e = pending.pop_front();
            if (idx !== e.idx || dep !== e.depth || o !== e.ovf || l !== e.last)
                report_mismatch($sformatf(
                    "got idx %0d depth %0d ovf %0b last %0b, want %0d %0d %0b %0b",
                    idx, dep, o, l, e.idx, e.depth, e.ovf, e.last));
        endtask

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask
    endclass

    logic clk, rst_n;
    logic in_valid, in_stall, last_item;
    logic [IDX_W-1:0] item_index;
    logic signed [PRI_W-1:0] item_priority;
    logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
    logic out_valid, out_stall, overflowed, last_out;
    logic [IDX_W-1:0] out_index;
    logic signed [DEPTH_W-1:0] out_depth;
    logic cfg_valid, cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    draw_order_scoreboard sb;
    int  idle_pct_out = 8;
    bit  hold_off = 0;
    int  quiet = 0;
    bit  pri_narrow;

    priority_depth_draw_sorter dut (.*);

    initial begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // One write per call; the trailing cycle keeps writes from overlapping.
    task automatic write_reg(logic [CFG_IDX_W-1:0] ri, logic [CFG_DATA_W-1:0] d);
        cfg_index <= ri;
        cfg_data  <= d;
        cfg_valid <= 1;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(ri, d);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    // Drive the given fields, sometimes idle first if allowed, then hold the beat until taken.
    task automatic send_item(logic [IDX_W-1:0] idx, logic [PRI_W-1:0] pri,
                             logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                             logic [POS_W-1:0] pz, logic lst, bit may_idle);
        while (may_idle && $urandom_range(99) < 8) begin
            in_valid <= 0;
            @(posedge clk);
        end
        item_index <= idx; item_priority <= pri;
        pos_x <= px; pos_y <= py; pos_z <= pz; last_item <= lst;
        in_valid <= 1;
        do @(posedge clk); while (in_stall);
        sb.note_item(idx, pri, px, py, pz, lst);
    endtask

    function automatic logic [POS_W-1:0] rand_pos();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(2000)) - 1000) << 16;
        endcase
    endfunction

    task automatic send_set(int n, bit may_idle);
        for (int i = 0; i < n; i++)
            send_item(16'($urandom), pri_narrow ? 16'($urandom_range(3)) : 16'($urandom),
                      rand_pos(), rand_pos(), rand_pos(), i == n - 1, may_idle);
        in_valid <= 0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic random_camera();
        for (int r = CFG_CAM_POS_X; r <= CFG_BACK_TO_FRONT; r++)
            write_reg(r[CFG_IDX_W-1:0], $urandom);
    endtask

    // Output side: random stall, with a forced long hold-off on request.
    always @(posedge clk) begin
        if (!rst_n) out_stall <= 0;
        else out_stall <= hold_off || ($urandom_range(99) < idle_pct_out);
        if (rst_n && out_valid && !out_stall)
            sb.check_beat(out_index, out_depth, overflowed, last_out);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > WATCH_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int total;
        sb = new();
        sb.reset_state();
        rst_n = 0; in_valid = 0; out_stall = 0; cfg_valid = 0;
        cfg_index = 0; cfg_data = 0; item_index = 0; item_priority = 0;
        pos_x = 0; pos_y = 0; pos_z = 0; last_item = 0;
        pri_narrow = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Reset camera: extreme fields, equal keys, single-item set.
        send_item(16'hFFFF, 16'h7FFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  1'b0, 1'b0);
        send_item(16'h0000, 16'h8000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  1'b0, 1'b0);
        send_item(16'h0001, 16'h0000, 0, 0, 32'h0001_0000, 1'b0, 1'b0);
        send_item(16'h0002, 16'h0000, 0, 0, 32'h0001_0000, 1'b0, 1'b0);
        send_item(16'h0003, 16'h0000, 0, 0, 32'hFFFF_0000, 1'b1, 1'b0);
        in_valid <= 0;
        drain();
        send_item(16'h5A5A, 16'hA5A5, 32'h5555_5555, 32'hAAAA_AAAA, 0, 1'b1, 1'b0);
        in_valid <= 0;
        drain();

        // Extreme camera, descending depth, unused register index.
        write_reg(CFG_CAM_POS_X, 32'h8000_0000);
        write_reg(CFG_CAM_POS_Y, 32'h7FFF_FFFF);
        write_reg(CFG_CAM_POS_Z, 32'h8000_0000);
        write_reg(CFG_CAM_DIR_X, 32'hFFFF_8000);
        write_reg(CFG_CAM_DIR_Y, 32'h0000_7FFF);
        write_reg(CFG_CAM_DIR_Z, 32'h1234_8000);
        write_reg(CFG_BACK_TO_FRONT, 32'hFFFF_FFFF);
        write_reg(CFG_UNUSED, 32'hDEAD_BEEF);
        pri_narrow = 1;
        send_set(6, 1'b0);
        drain();

        // Overflow: three items over capacity, all three (last included) dropped; receiver holds off.
        hold_off = 1;
        fork
            send_set(CAP + 3, 1'b0);
            begin
                repeat (400) @(posedge clk);
                hold_off = 0;
            end
        join
        drain();
        write_reg(CFG_BACK_TO_FRONT, 0);

        // Random sets, first a stretch with no idling at all.
        total = 0;
        idle_pct_out = 0;
        send_set(12, 1'b0);
        drain();
        idle_pct_out = 8;
        while (total < 140) begin
            int n;
            if ($urandom_range(3) == 0) random_camera();
            pri_narrow = $urandom_range(1);
            n = ($urandom_range(9) == 0) ? $urandom_range(CAP + 2, 40)
                                         : $urandom_range(12, 1);
            send_set(n, 1'b1);
            total += n;
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
